>>> sv/srsw_pkg.sv
// ----------------------------------------------------------------------------
// srsw_pkg
// Shared constants and control types for the selective-repeat sender window.
// ----------------------------------------------------------------------------
`default_nettype none

package srsw_pkg;

   // Sequence numbering
   localparam int SEQ_MODULUS = 8;
   localparam int SEQ_W       = 3;

   // Field and register widths
   localparam int LIMIT_W     = 3;
   localparam int TIMER_W     = 10;
   localparam int ACTION_W    = 2;
   localparam int CSR_ADDR_W  = 1;
   localparam int CSR_DATA_W  = 10;
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 16;

   // Action codes carried in req_tuser
   localparam logic [ACTION_W-1:0] ACT_SEND = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ACK  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_TICK = 2'd2;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_WINDOW_LIMIT  = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_TIMEOUT_TICKS = 1'b1;

   // Register reset values
   localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 3'd4;
   localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 10'd3;

   // Controller to datapath commands
   typedef struct packed {
      logic take;   // latch the accepted request word
      logic exec;   // run the request against the window
      logic pop;    // retire the acknowledged window head
      logic load;   // move the result into the output register
   } srsw_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic ack_hit;   // ack matched an entry, window may slide
      logic can_pop;   // head entry is occupied and acknowledged
      logic out_free;  // output register can take a word this cycle
   } srsw_status_type;

endpackage

`default_nettype wire

>>> sv/srsw_ctrl.sv
// ----------------------------------------------------------------------------
// srsw_ctrl
// Sequencer: accept a request, run it, slide the window, hand off the result.
// ----------------------------------------------------------------------------
`default_nettype none

module srsw_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_tvalid,
   output logic                     req_tready,
   input  srsw_pkg::srsw_status_type status,
   output srsw_pkg::srsw_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_EXEC   = 4'b0010,
      ST_SLIDE  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Take a new word when idle, or while handing off the previous result
   assign req_tready = (state_ff == ST_IDLE) ||
                       ((state_ff == ST_FINISH) && status.out_free);

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.take  = req_tvalid && req_tready;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = status.ack_hit ? ST_SLIDE : ST_FINISH;
         end
         ST_SLIDE: begin
            if (status.can_pop) begin
               cmd.pop = 1'b1;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = req_tvalid ? ST_EXEC : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef NO_ASSERTIONS
   // An accepted word is always executed in the following cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.take |=> (state_ff == ST_EXEC))
      else $error("srsw_ctrl: accepted word not executed next cycle");

   // The window never slides in the same cycle a result is handed off
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.pop && cmd.load))
      else $error("srsw_ctrl: pop and load overlap");
`endif

endmodule

`default_nettype wire

>>> sv/srsw_datapath.sv
// ----------------------------------------------------------------------------
// srsw_datapath
// Window storage, sequence and timer state, registers and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module srsw_datapath #(
   parameter int WINDOW_SLOTS = 4
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  srsw_pkg::srsw_cmd_type                  cmd,
   output srsw_pkg::srsw_status_type               status,
   input  wire [srsw_pkg::ACTION_W-1:0]            req_action,
   input  wire [srsw_pkg::SEQ_W-1:0]               req_ack_seq,
   input  wire                                    req_ack_last,
   input  wire                                    req_data_last,
   input  wire                                    csr_we,
   input  wire [srsw_pkg::CSR_ADDR_W-1:0]          csr_addr,
   input  wire [srsw_pkg::CSR_DATA_W-1:0]          csr_wdata,
   output logic                                   rsp_tvalid,
   input  wire                                    rsp_tready,
   output logic [srsw_pkg::RSP_TDATA_W-1:0]        rsp_tdata,
   output logic                                   rsp_tlast
);

   localparam int SLOT_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
   localparam int CNT_W  = $clog2(WINDOW_SLOTS + 1);
   localparam int SUM_W  = CNT_W + 1;
   localparam int CMP_W  = (CNT_W > srsw_pkg::LIMIT_W) ? CNT_W : srsw_pkg::LIMIT_W;

   // Slot index at an offset from a base, wrapping around the window
   function automatic logic [SLOT_W-1:0] wrap_slot(input logic [SLOT_W-1:0] base,
                                                   input logic [CNT_W-1:0]  off);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(off);
      if (sum >= SUM_W'(WINDOW_SLOTS)) begin
         sum = sum - SUM_W'(WINDOW_SLOTS);
      end
      return SLOT_W'(sum);
   endfunction

   // Window storage
   logic [srsw_pkg::SEQ_W-1:0] slot_seq_ff   [WINDOW_SLOTS];
   logic [srsw_pkg::SEQ_W-1:0] slot_seq_in   [WINDOW_SLOTS];
   logic                       slot_acked_ff [WINDOW_SLOTS];
   logic                       slot_acked_in [WINDOW_SLOTS];
   logic                       slot_last_ff  [WINDOW_SLOTS];
   logic                       slot_last_in  [WINDOW_SLOTS];

   // Window control state
   logic [SLOT_W-1:0]            head_ff,     head_in;
   logic [CNT_W-1:0]             occ_ff,      occ_in;
   logic [srsw_pkg::SEQ_W-1:0]   next_seq_ff, next_seq_in;
   logic [srsw_pkg::TIMER_W-1:0] elapsed_ff,  elapsed_in;
   logic                         finished_ff, finished_in;

   // Configuration registers
   logic [srsw_pkg::LIMIT_W-1:0] limit_ff,   limit_in;
   logic [srsw_pkg::TIMER_W-1:0] timeout_ff, timeout_in;

   // Latched request word
   logic [srsw_pkg::ACTION_W-1:0] action_ff;
   logic [srsw_pkg::SEQ_W-1:0]    ack_seq_ff;
   logic                          ack_last_ff;
   logic                          data_last_ff;

   // Pending result of the executed word
   logic                       pend_accepted_ff, pend_accepted_in;
   logic                       pend_valid_ff,    pend_valid_in;
   logic [srsw_pkg::SEQ_W-1:0] pend_seq_ff,      pend_seq_in;
   logic                       pend_retx_ff,     pend_retx_in;
   logic                       pend_last_ff,     pend_last_in;
   logic                       pend_err_ff,      pend_err_in;

   // Output register
   logic                       out_valid_ff;
   logic                       out_accepted_ff;
   logic                       out_send_ff;
   logic [srsw_pkg::SEQ_W-1:0] out_seq_ff;
   logic                       out_retx_ff;
   logic                       out_last_ff;
   logic [2:0]                 out_free_ff;
   logic                       out_err_ff;
   logic                       out_done_ff;

   // Effective limit and free slots
   logic [CMP_W-1:0] limit_ext;
   logic [CMP_W-1:0] lim_cmp;
   logic [CNT_W-1:0] lim;
   logic [CNT_W-1:0] free_now;

   // Ack search
   logic              found;
   logic [SLOT_W-1:0] hit_slot;

   assign limit_ext = CMP_W'(limit_ff);
   assign lim_cmp   = (limit_ext < CMP_W'(WINDOW_SLOTS)) ? limit_ext : CMP_W'(WINDOW_SLOTS);
   assign lim       = CNT_W'(lim_cmp);
   assign free_now  = (occ_ff < lim) ? (lim - occ_ff) : '0;

   // Find the oldest occupied entry that carries the acked sequence number
   always_comb begin
      found    = 1'b0;
      hit_slot = '0;
      for (int i = 0; i < WINDOW_SLOTS; i++) begin
         if (!found && (CNT_W'(i) < occ_ff) &&
             (slot_seq_ff[wrap_slot(head_ff, CNT_W'(i))] == ack_seq_ff)) begin
            found    = 1'b1;
            hit_slot = wrap_slot(head_ff, CNT_W'(i));
         end
      end
   end

   // Status to the controller
   assign status.ack_hit  = !finished_ff && (action_ff == srsw_pkg::ACT_ACK) && found;
   assign status.can_pop  = (occ_ff != '0) && slot_acked_ff[head_ff];
   assign status.out_free = !out_valid_ff || rsp_tready;

   // Window update: execute a word, or retire the head
   always_comb begin
      slot_seq_in      = slot_seq_ff;
      slot_acked_in    = slot_acked_ff;
      slot_last_in     = slot_last_ff;
      head_in          = head_ff;
      occ_in           = occ_ff;
      next_seq_in      = next_seq_ff;
      elapsed_in       = elapsed_ff;
      finished_in      = finished_ff;
      pend_accepted_in = pend_accepted_ff;
      pend_valid_in    = pend_valid_ff;
      pend_seq_in      = pend_seq_ff;
      pend_retx_in     = pend_retx_ff;
      pend_last_in     = pend_last_ff;
      pend_err_in      = pend_err_ff;

      if (cmd.exec) begin
         pend_accepted_in = 1'b0;
         pend_valid_in    = 1'b0;
         pend_seq_in      = '0;
         pend_retx_in     = 1'b0;
         pend_last_in     = 1'b0;
         pend_err_in      = 1'b0;
         if (!finished_ff) begin
            case (action_ff)
               srsw_pkg::ACT_SEND: begin
                  // Take the next free slot and number the packet
                  if (occ_ff < lim) begin
                     slot_seq_in[wrap_slot(head_ff, occ_ff)]   = next_seq_ff;
                     slot_acked_in[wrap_slot(head_ff, occ_ff)] = 1'b0;
                     slot_last_in[wrap_slot(head_ff, occ_ff)]  = data_last_ff;
                     if (occ_ff == '0) begin
                        elapsed_in = '0;
                     end
                     occ_in           = occ_ff + 1'b1;
                     pend_accepted_in = 1'b1;
                     pend_valid_in    = 1'b1;
                     pend_seq_in      = next_seq_ff;
                     pend_last_in     = data_last_ff;
                     next_seq_in      = (next_seq_ff == srsw_pkg::SEQ_W'(srsw_pkg::SEQ_MODULUS - 1))
                                        ? '0 : next_seq_ff + 1'b1;
                  end
               end
               srsw_pkg::ACT_ACK: begin
                  // Mark the matching entry; an unmatched ack only flags
                  if (found) begin
                     slot_acked_in[hit_slot] = 1'b1;
                     if (ack_last_ff) begin
                        finished_in = 1'b1;
                     end
                  end else begin
                     pend_err_in = 1'b1;
                  end
               end
               srsw_pkg::ACT_TICK: begin
                  // Advance the timer; resend the head once it has run out
                  if (occ_ff != '0) begin
                     if (elapsed_ff >= timeout_ff) begin
                        pend_valid_in = 1'b1;
                        pend_retx_in  = 1'b1;
                        pend_seq_in   = slot_seq_ff[head_ff];
                        pend_last_in  = slot_last_ff[head_ff];
                        elapsed_in    = '0;
                     end else begin
                        elapsed_in = elapsed_ff + 1'b1;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end else if (cmd.pop) begin
         // Retire the acknowledged head and restart the timer
         slot_acked_in[head_ff] = 1'b0;
         head_in                = wrap_slot(head_ff, CNT_W'(1));
         occ_in                 = occ_ff - 1'b1;
         elapsed_in             = '0;
      end
   end

   // Register writes
   always_comb begin
      limit_in   = limit_ff;
      timeout_in = timeout_ff;
      if (csr_we) begin
         case (csr_addr)
            srsw_pkg::CSR_WINDOW_LIMIT:  limit_in   = csr_wdata[srsw_pkg::LIMIT_W-1:0];
            srsw_pkg::CSR_TIMEOUT_TICKS: timeout_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Control state and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_acked_ff <= '{default: 1'b0};
         slot_last_ff  <= '{default: 1'b0};
         head_ff       <= '0;
         occ_ff        <= '0;
         next_seq_ff   <= '0;
         elapsed_ff    <= '0;
         finished_ff   <= 1'b0;
         limit_ff      <= srsw_pkg::LIMIT_RESET;
         timeout_ff    <= srsw_pkg::TIMEOUT_RESET;
         out_valid_ff  <= 1'b0;
      end else begin
         slot_acked_ff <= slot_acked_in;
         slot_last_ff  <= slot_last_in;
         head_ff       <= head_in;
         occ_ff        <= occ_in;
         next_seq_ff   <= next_seq_in;
         elapsed_ff    <= elapsed_in;
         finished_ff   <= finished_in;
         limit_ff      <= limit_in;
         timeout_ff    <= timeout_in;
         if (cmd.load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload: sequence store, request word, pending and output result
   always_ff @(posedge clock) begin
      slot_seq_ff      <= slot_seq_in;
      pend_accepted_ff <= pend_accepted_in;
      pend_valid_ff    <= pend_valid_in;
      pend_seq_ff      <= pend_seq_in;
      pend_retx_ff     <= pend_retx_in;
      pend_last_ff     <= pend_last_in;
      pend_err_ff      <= pend_err_in;
      if (cmd.take) begin
         action_ff    <= req_action;
         ack_seq_ff   <= req_ack_seq;
         ack_last_ff  <= req_ack_last;
         data_last_ff <= req_data_last;
      end
      if (cmd.load) begin
         out_accepted_ff <= pend_accepted_ff;
         out_send_ff     <= pend_valid_ff;
         out_seq_ff      <= pend_seq_ff;
         out_retx_ff     <= pend_retx_ff;
         out_last_ff     <= pend_last_ff;
         out_free_ff     <= 3'(free_now);
         out_err_ff      <= pend_err_ff;
         out_done_ff     <= finished_ff;
      end
   end

   // Result word
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {4'b0000, out_done_ff, out_err_ff, out_free_ff, out_retx_ff,
                        out_seq_ff[0], out_seq_ff, out_send_ff, out_accepted_ff};

`ifndef NO_ASSERTIONS
   // The window never holds more entries than it has slots
   assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CNT_W'(WINDOW_SLOTS))
      else $error("srsw_datapath: occupancy beyond window size");

   // A result is loaded only when the output register can take it
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!out_valid_ff || rsp_tready))
      else $error("srsw_datapath: result loaded over an untaken word");

   // Once the transfer is done it stays done
   assert property (@(posedge clock) disable iff (reset)
      finished_ff |=> finished_ff)
      else $error("srsw_datapath: finished flag dropped");
`endif

endmodule

`default_nettype wire

>>> sv/selective_repeat_sender_window.sv
// ----------------------------------------------------------------------------
// selective_repeat_sender_window
// Sender window of a selective-repeat link: slot allocation, acks, timeouts.
// ----------------------------------------------------------------------------
//  channel | direction | ports              | contents
//  --------+-----------+--------------------+--------------------------------
//  req     | in        | tvalid/tready/...  | send, ack or timer tick word
//  rsp     | out       | tvalid/tready/...  | one result word per request
//  csr     | in        | we/addr/wdata      | window limit, timeout ticks
//
//  A send, tick or unmatched ack passes from acceptance through the execute
//  and finish states to the result; a matched ack also passes through the
//  slide state, which retires one acknowledged entry per cycle from the head.
//  The next word is accepted in the cycle the previous result is handed off.
//  A stalled rsp side holds the result and stops new words at that point.
//  Reset is synchronous; there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module selective_repeat_sender_window #(
   parameter int WINDOW_SLOTS = 4
) (
   input  wire                                  clock,
   input  wire                                  reset,
   // req_tdata: ack_seq[2:0], ack_last[3], zero[7:4]
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   input  wire [srsw_pkg::REQ_TDATA_W-1:0]       req_tdata,
   // req_tuser: action[1:0]
   input  wire [srsw_pkg::ACTION_W-1:0]          req_tuser,
   input  wire                                  req_tlast,
   // rsp_tdata: accepted[0], send_valid[1], send_seq[4:2], relay_select[5],
   //            retransmit[6], free_slots[9:7], ack_error[10], done_res[11],
   //            zero[15:12]
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic [srsw_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tlast,
   input  wire                                  csr_we,
   input  wire [srsw_pkg::CSR_ADDR_W-1:0]        csr_addr,
   input  wire [srsw_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   srsw_pkg::srsw_cmd_type    cmd;
   srsw_pkg::srsw_status_type status;

   // Sequencer
   srsw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Window state and result register
   srsw_datapath #(
      .WINDOW_SLOTS (WINDOW_SLOTS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_action    (req_tuser),
      .req_ack_seq   (req_tdata[2:0]),
      .req_ack_last  (req_tdata[3]),
      .req_data_last (req_tlast),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast)
   );

endmodule

`default_nettype wire
